/* sv/bps_pkg.sv */
// Shared types and constants for the board power sequencer.
// Used by the channel interfaces, the sequencer core and the top level; depends on nothing.
`default_nettype none

package bps_pkg;

	// Input beat mode.
	typedef enum logic {
		MODE_LOGIC = 1'b0,
		MODE_TICK  = 1'b1
	} mode_t;

	// Board sequence states, encoded as reported on the result channel.
	typedef enum logic [1:0] {
		SEQ_START = 2'd0,
		SEQ_WORK  = 2'd1,
		SEQ_GOOFF = 2'd2,
		SEQ_OFF   = 2'd3
	} seq_state_t;

	// Button command codes; any other code means no command.
	localparam logic [1:0] BTN_SOFT_OFF = 2'd1;
	localparam logic [1:0] BTN_HARD_OFF = 2'd2;

	// Configuration register indexes.
	typedef enum logic {
		CFG_START_MIN = 1'b0,
		CFG_RUN_MIN   = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] START_MIN_RESET = 16'd9000;
	localparam logic [15:0] RUN_MIN_RESET   = 16'd9500;

	// Back timer loads, in one-second ticks.
	localparam logic [5:0] BT_RESET = 6'd10;
	localparam logic [5:0] BT_LONG  = 6'd60;
	localparam logic [5:0] BT_SHORT = 6'd5;
	localparam logic [5:0] BT_FINAL = 6'd3;

	// The link timeout is reloaded with 80 outside this block, which is above this threshold.
	localparam logic [15:0] LINK_LOW = 16'd50;

	// LED pattern codes.
	localparam logic [3:0] LED_READY = 4'd0;
	localparam logic [3:0] LED_START = 4'd4;
	localparam logic [3:0] LED_HOST  = 4'd5;
	localparam logic [3:0] LED_LINK  = 4'd6;
	localparam logic [3:0] LED_SOFT  = 4'd7;
	localparam logic [3:0] LED_OFF   = 4'd8;

	// Rail enable bit positions.
	localparam int RAIL_PPM = 0;
	localparam int RAIL_SRV = 1;
	localparam int RAIL_5V  = 2;
	localparam int RAIL_ALL = 3;

	typedef struct packed {
		logic [15:0] start_min_mv;
		logic [15:0] run_min_mv;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] battery_mv;
		logic        usb_present;
		logic [1:0]  button_cmd;
		logic [15:0] link_timeout_left;
	} in_item_t;

	typedef struct packed {
		logic [1:0] board_state;
		logic [3:0] led_state;
		logic       shutdown_req;
		logic       host_on;
		logic       host_soft_off;
		logic       ppm_power;
		logic       servo_power;
		logic       dc5v_power;
		logic       all_power;
		logic       load_link_timeout;
		logic       button_clear;
		logic       timer_expired;
	} out_item_t;

endpackage

`default_nettype wire

/* sv/bps_in_if.sv */
// Valid/ready channel that carries input beats into the sequencer.
// Depends on bps_pkg for the payload type.
`default_nettype none

interface bps_in_if;
	logic               valid;
	logic               ready;
	bps_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/bps_out_if.sv */
// Valid/ready channel that carries result beats out of the sequencer.
// Depends on bps_pkg for the payload type.
`default_nettype none

interface bps_out_if;
	logic               valid;
	logic               ready;
	bps_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/bps_core.sv */
// Sequencer state registers and the single-pass next-state logic.
// Depends on bps_pkg; instantiated by board_power_sequencer_unit.
`default_nettype none

module bps_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire bps_pkg::in_item_t  item,
	input  wire bps_pkg::cfg_t      cfg,
	output      bps_pkg::out_item_t result
);

	bps_pkg::seq_state_t state_q, state_d;
	logic [5:0] timer_q, timer_d;
	logic [3:0] led_q, led_d;
	logic       shut_q, shut_d;
	logic       host_on_q, host_on_d;
	logic       soft_off_q, soft_off_d;
	logic [3:0] rails_q, rails_d;
	logic       load_d, clr_d, expired_d;
	logic       timer_zero;
	logic       hard_off;

	assign timer_zero = (timer_q == 6'd0);
	assign hard_off   = (item.button_cmd == bps_pkg::BTN_HARD_OFF);

	always_comb begin
		state_d    = state_q;
		timer_d    = timer_q;
		led_d      = led_q;
		shut_d     = shut_q;
		host_on_d  = host_on_q;
		soft_off_d = soft_off_q;
		rails_d    = rails_q;
		load_d     = 1'b0;
		clr_d      = 1'b0;
		expired_d  = 1'b0;

		if (item.mode == bps_pkg::MODE_TICK) begin
			if (timer_zero) begin
				expired_d = 1'b1;
			end else begin
				timer_d = timer_q - 6'd1;
			end
		end else begin
			// LED phase advance runs before the sequence step can override it.
			if (led_d == bps_pkg::LED_START && host_on_q) begin
				led_d = bps_pkg::LED_HOST;
			end
			if (led_d == bps_pkg::LED_HOST && item.usb_present) begin
				led_d  = bps_pkg::LED_LINK;
				load_d = 1'b1;
			end
			// A timeout just reloaded is never below the threshold.
			if (led_d == bps_pkg::LED_LINK && !load_d &&
					item.link_timeout_left < bps_pkg::LINK_LOW) begin
				led_d = bps_pkg::LED_READY;
			end

			case (state_q)
				bps_pkg::SEQ_START: begin
					if (timer_zero) begin
						if (item.battery_mv < cfg.start_min_mv) begin
							timer_d                      = bps_pkg::BT_SHORT;
							shut_d                       = 1'b1;
							rails_d[bps_pkg::RAIL_PPM]   = 1'b0;
							rails_d[bps_pkg::RAIL_SRV]   = 1'b0;
							state_d                      = bps_pkg::SEQ_GOOFF;
						end else begin
							state_d   = bps_pkg::SEQ_WORK;
							host_on_d = 1'b1;
						end
					end
				end
				bps_pkg::SEQ_WORK: begin
					if (item.battery_mv < cfg.run_min_mv) begin
						timer_d                    = bps_pkg::BT_LONG;
						shut_d                     = 1'b1;
						rails_d[bps_pkg::RAIL_PPM] = 1'b0;
						rails_d[bps_pkg::RAIL_SRV] = 1'b0;
						state_d                    = bps_pkg::SEQ_GOOFF;
					end else if (item.button_cmd == bps_pkg::BTN_SOFT_OFF) begin
						clr_d                      = 1'b1;
						timer_d                    = bps_pkg::BT_LONG;
						shut_d                     = 1'b1;
						soft_off_d                 = 1'b1;
						rails_d[bps_pkg::RAIL_PPM] = 1'b0;
						rails_d[bps_pkg::RAIL_SRV] = 1'b0;
						led_d                      = bps_pkg::LED_SOFT;
						state_d                    = bps_pkg::SEQ_GOOFF;
					end else if (hard_off) begin
						soft_off_d = 1'b1;
						timer_d    = bps_pkg::BT_FINAL;
						shut_d     = 1'b1;
						state_d    = bps_pkg::SEQ_OFF;
					end
				end
				bps_pkg::SEQ_GOOFF: begin
					if (!item.usb_present || hard_off || timer_zero) begin
						soft_off_d                = 1'b1;
						rails_d[bps_pkg::RAIL_5V] = 1'b0;
						timer_d                   = bps_pkg::BT_FINAL;
						led_d                     = bps_pkg::LED_OFF;
						state_d                   = bps_pkg::SEQ_OFF;
					end
				end
				default: begin
					if (timer_zero) begin
						rails_d[bps_pkg::RAIL_ALL] = 1'b0;
					end
				end
			endcase
		end
	end

	always_comb begin
		result.board_state       = state_d;
		result.led_state         = led_d;
		result.shutdown_req      = shut_d;
		result.host_on           = host_on_d;
		result.host_soft_off     = soft_off_d;
		result.ppm_power         = rails_d[bps_pkg::RAIL_PPM];
		result.servo_power       = rails_d[bps_pkg::RAIL_SRV];
		result.dc5v_power        = rails_d[bps_pkg::RAIL_5V];
		result.all_power         = rails_d[bps_pkg::RAIL_ALL];
		result.load_link_timeout = load_d;
		result.button_clear      = clr_d;
		result.timer_expired     = expired_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bps_pkg::SEQ_START;
			timer_q    <= bps_pkg::BT_RESET;
			led_q      <= bps_pkg::LED_START;
			shut_q     <= 1'b0;
			host_on_q  <= 1'b0;
			soft_off_q <= 1'b0;
			rails_q    <= '1;
		end else if (step) begin
			state_q    <= state_d;
			timer_q    <= timer_d;
			led_q      <= led_d;
			shut_q     <= shut_d;
			host_on_q  <= host_on_d;
			soft_off_q <= soft_off_d;
			rails_q    <= rails_d;
		end
	end

	// A tick beat only ever touches the back timer.
	a_tick_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == bps_pkg::MODE_TICK |=> $stable(state_q) && $stable(rails_q))
		else $error("tick beat changed sequence state or rails");

	// Once the main hold is released it never comes back without a reset.
	a_all_power_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!rails_q[bps_pkg::RAIL_ALL] |=> !rails_q[bps_pkg::RAIL_ALL])
		else $error("main power hold re-enabled");

	// The board can only be off or going off with shutdown requested; every path into
	// either state raises the flag.
	a_shutdown_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bps_pkg::SEQ_GOOFF || state_q == bps_pkg::SEQ_OFF) |-> shut_q)
		else $error("shutdown state without shutdown request");

	// Host power-on command, once given, is never withdrawn.
	a_host_on_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		host_on_q |=> host_on_q)
		else $error("host power-on command dropped");

endmodule

`default_nettype wire

/* sv/board_power_sequencer_unit.sv */
// Top level of the board power sequencer: input stage, configuration registers, result register.
// Depends on bps_pkg, bps_in_if, bps_out_if and bps_core.
`default_nettype none

// The sequencer takes one beat per clock while results are taken, and returns exactly one
// result beat for each, in order. A beat is either a logic pass, which advances the LED phase
// and steps the board through starting, working, going off and off, or a one-second tick,
// which only counts the back timer down and reports when it was already zero. Each beat is
// captured in an input register. In the following cycle the sequencer core works out the new
// state in one pass of combinational logic. When the beat can move on, with the result register
// free or being emptied, the core commits that state to its state registers and the result
// register is loaded, and the result is offered from there. The input and result registers are
// separate stages, so a new beat is taken while a finished result still waits on a stalled
// result channel. Sustained throughput is one beat per clock whenever the result side is
// ready. The result always shows the state after the beat. The two battery thresholds are
// written through the plain write port (index 0 start minimum, index 1 run minimum) and
// should only be changed while no beat is in flight. The link timeout counter itself lives
// outside: this block only requests its reload to 80 and reads its current value.
module board_power_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bps_in_if.sink           items,
	bps_out_if.source        results,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	bps_pkg::cfg_t      cfg_q;
	bps_pkg::in_item_t  item_s1;
	logic               valid_s1;
	bps_pkg::out_item_t result_d;
	bps_pkg::out_item_t result_q;
	logic               res_valid_q;
	logic               step;

	// The stage-one beat moves on whenever the result register is free or being emptied.
	assign step        = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_min_mv <= bps_pkg::START_MIN_RESET;
			cfg_q.run_min_mv   <= bps_pkg::RUN_MIN_RESET;
		end else if (cfg_we) begin
			case (bps_pkg::cfg_reg_t'(cfg_index))
				bps_pkg::CFG_START_MIN: cfg_q.start_min_mv <= cfg_data;
				bps_pkg::CFG_RUN_MIN:   cfg_q.run_min_mv   <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.payload;
		end
	end

	bps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

	assign results.valid   = res_valid_q;
	assign results.payload = result_q;

endmodule

`default_nettype wire
